### rtl/core/tcpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

	localparam int unsigned DEF_CAPACITY = 8;
	localparam int unsigned NUM_CLASSES  = 3;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_SEND = 1'b1;

	localparam logic [1:0] ST_ADDED    = 2'd0;
	localparam logic [1:0] ST_REJECTED = 2'd1;
	localparam logic [1:0] ST_SENT     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	localparam logic [1:0] CLS_ACCIDENT = 2'd0;
	localparam logic [1:0] CLS_ORDER    = 2'd1;
	localparam logic [1:0] CLS_TEMP     = 2'd2;

	typedef struct packed {
		logic       temp_flag;
		logic [1:0] order_code;
	} entry_t;

	typedef struct packed {
		logic       is_send;
		logic [1:0] cls;
		logic       pure_temp;
		entry_t     entry;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/core/tcpq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcpq_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [1:0] order_code;
	logic       temp_flag;
	logic       accident_flag;

	modport source(output valid, output opcode, output order_code, output temp_flag,
		output accident_flag, input ready);
	modport sink(input valid, input opcode, input order_code, input temp_flag,
		input accident_flag, output ready);
endinterface

`default_nettype wire

### rtl/core/tcpq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcpq_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       evicted;
	logic [1:0] sent_class;
	logic [1:0] sent_order_code;
	logic       sent_temp_flag;
	logic [3:0] pending_count;

	modport source(output valid, output status, output evicted, output sent_class,
		output sent_order_code, output sent_temp_flag, output pending_count, input ready);
	modport sink(input valid, input status, input evicted, input sent_class,
		input sent_order_code, input sent_temp_flag, input pending_count, output ready);
endinterface

`default_nettype wire

### rtl/core/three_class_priority_message_queue.sv
// a taken request is queued in the front end and its result registered in the
// back end; throughput: one request per cycle while rsp.ready holds, set by the
// head, tail and count update; a two-entry command queue decouples the front end
// reset: class counts, read pointers, total and all valid flags clear at once;
// the class stores are not cleared and hold garbage until written
`timescale 1ns / 1ps
`default_nettype none

module three_class_priority_message_queue import tcpq_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_CAPACITY
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tcpq_req_if.sink   req,
	tcpq_rsp_if.source rsp
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	tcpq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	tcpq_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);

	a_evict_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.evicted |-> rsp.pending_count == 4'(CAPACITY))
		else $error("eviction reported while not full");

	a_reject_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_REJECTED) |-> rsp.pending_count == 4'(CAPACITY))
		else $error("reject reported while not full");

	a_empty_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_EMPTY) |-> rsp.pending_count == 4'd0)
		else $error("send on empty with entries pending");

	a_send_never_evicts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_SENT || rsp.status == ST_EMPTY) |-> !rsp.evicted)
		else $error("send beat flagged as eviction");

endmodule

`default_nettype wire

### rtl/core/tcpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcpq_ram #(
	parameter int unsigned WIDTH = 3,
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/tcpq_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tcpq_front import tcpq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	tcpq_req_if.sink  req,
	output logic      cmd_valid,
	output cmd_t      cmd,
	input  wire logic cmd_ready
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       cmd_in;
	logic       push;
	logic       pop;

	// classify the incoming beat
	always_comb begin
		cmd_in.is_send          = (req.opcode == OP_SEND);
		cmd_in.cls              = req.accident_flag ? CLS_ACCIDENT :
			((req.order_code != 2'b00) ? CLS_ORDER : CLS_TEMP);
		cmd_in.pure_temp        = req.temp_flag && (req.order_code == 2'b00) &&
			!req.accident_flag;
		cmd_in.entry.temp_flag  = req.temp_flag;
		cmd_in.entry.order_code = req.order_code;
	end

	assign req.ready = (fill_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

`default_nettype wire

### rtl/core/tcpq_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tcpq_back import tcpq_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_CAPACITY
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	input  wire cmd_t  cmd,
	output logic       cmd_ready,
	tcpq_rsp_if.source rsp
);

	localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [PW:0]   CAP_P = (PW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [PW-1:0] rp_q  [NUM_CLASSES];
	logic [CW-1:0] cnt_q [NUM_CLASSES];
	logic [CW-1:0] total_q;

	logic [CW-1:0] cnt_d [NUM_CLASSES];
	logic [CW-1:0] total_d;
	logic [PW-1:0] rp_next [NUM_CLASSES];
	logic [2:0]    nonempty;
	logic [1:0]    ev_cls;
	logic [1:0]    send_cls;
	logic          full;
	logic          fire;
	logic          reject;
	logic          do_evict;
	logic          do_add;
	logic          do_send;
	logic [CW-1:0] add_cnt;
	logic [PW:0]   wsum;
	logic [PW-1:0] waddr;
	logic [1:0]    status_d;

	logic [NUM_CLASSES-1:0] we;
	logic [NUM_CLASSES-1:0] re;
	entry_t                 rd_data [NUM_CLASSES];

	logic          out_valid_q;
	logic [1:0]    status_q;
	logic          evicted_q;
	logic [1:0]    sent_cls_q;
	logic          sent_hit_q;
	logic [CW-1:0] pending_q;
	logic [CW+3:0] pending_ext;
	entry_t        sent_entry;

	assign fire      = cmd_valid && (!out_valid_q || rsp.ready);
	assign cmd_ready = !out_valid_q || rsp.ready;

	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			nonempty[c] = (cnt_q[c] != '0);
		end
		full     = (total_q >= CAP_C);
		ev_cls   = nonempty[2] ? CLS_TEMP : (nonempty[1] ? CLS_ORDER : CLS_ACCIDENT);
		send_cls = nonempty[0] ? CLS_ACCIDENT : (nonempty[1] ? CLS_ORDER : CLS_TEMP);
		reject   = !cmd.is_send && full && cmd.pure_temp;
		do_evict = !cmd.is_send && full && !cmd.pure_temp;
		do_add   = !cmd.is_send && !reject;
		do_send  = cmd.is_send && (nonempty != 3'b000);

		// tail slot of the target class after any eviction
		add_cnt = cnt_q[cmd.cls] - CW'(do_evict && (ev_cls == cmd.cls));
		wsum    = {1'b0, rp_q[cmd.cls]} + (PW + 1)'(add_cnt);
		waddr   = (wsum >= CAP_P) ? PW'(wsum - CAP_P) : wsum[PW-1:0];

		for (int c = 0; c < NUM_CLASSES; c++) begin
			rp_next[c] = (({1'b0, rp_q[c]} + 1'b1) == CAP_P) ? '0 : rp_q[c] + 1'b1;
			cnt_d[c]   = cnt_q[c]
				+ CW'(do_add && (cmd.cls == 2'(c)))
				- CW'((do_evict && (ev_cls == 2'(c))) || (do_send && (send_cls == 2'(c))));
			we[c]      = fire && do_add && (cmd.cls == 2'(c));
			re[c]      = fire && do_send && (send_cls == 2'(c));
		end
		total_d = total_q + CW'(do_add) - CW'(do_evict || do_send);

		if (cmd.is_send) begin
			status_d = do_send ? ST_SENT : ST_EMPTY;
		end else begin
			status_d = reject ? ST_REJECTED : ST_ADDED;
		end
	end

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_store
		tcpq_ram #(
			.WIDTH ($bits(entry_t)),
			.DEPTH (CAPACITY)
		) u_store (
			.clk   (clk),
			.we    (we[g]),
			.waddr (waddr),
			.wdata (cmd.entry),
			.re    (re[g]),
			.raddr (rp_q[g]),
			.rdata (rd_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				rp_q[c]  <= '0;
				cnt_q[c] <= '0;
			end
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				for (int c = 0; c < NUM_CLASSES; c++) begin
					cnt_q[c] <= cnt_d[c];
					if (re[c]) begin
						rp_q[c] <= rp_next[c];
					end
				end
				total_q     <= total_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q   <= status_d;
			evicted_q  <= do_evict;
			sent_cls_q <= send_cls;
			sent_hit_q <= do_send;
			pending_q  <= total_d;
		end
	end

	// store read data stays put while the beat waits
	always_comb begin
		case (sent_cls_q)
			CLS_ACCIDENT: sent_entry = rd_data[0];
			CLS_ORDER:    sent_entry = rd_data[1];
			CLS_TEMP:     sent_entry = rd_data[2];
			default:      sent_entry = '0;
		endcase
	end

	assign pending_ext         = {4'b0000, pending_q};
	assign rsp.valid           = out_valid_q;
	assign rsp.status          = status_q;
	assign rsp.evicted         = evicted_q;
	assign rsp.sent_class      = sent_hit_q ? sent_cls_q : 2'b00;
	assign rsp.sent_order_code = sent_hit_q ? sent_entry.order_code : 2'b00;
	assign rsp.sent_temp_flag  = sent_hit_q ? sent_entry.temp_flag : 1'b0;
	assign rsp.pending_count   = pending_ext[3:0];

endmodule

`default_nettype wire
